### design/tqr_pkg.sv
// ----------------------------------------------------------------------------
// tqr_pkg: shared types for the two-queue rotation block
// Request and result structs, command and status codes, and the control
// groups passed from the top level to the queues and from a queue to its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tqr_pkg;

  // Port field widths
  localparam int unsigned KEY_W = 16;
  localparam int unsigned PAY_W = 7;
  localparam int unsigned CNT_W = 5;

  // Commands
  typedef enum logic [1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_ENTER  = 2'd1,
    CMD_LEAVE  = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // One request
  typedef struct packed {
    cmd_e             mode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  // One result
  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
    logic [CNT_W-1:0] waiting_count;
    logic [CNT_W-1:0] active_count;
  } res_t;

  // Operation on one queue for the current request
  typedef struct packed {
    logic push;      // append at the tail
    logic pop_head;  // take the head
    logic del_key;   // take the first entry with a matching key
  } q_ctrl_t;

  // Control seen by every cell of a queue
  typedef struct packed {
    logic shift_all; // every cell takes its right neighbour
    logic key_en;    // cells from the first match onwards take their neighbour
    logic load;      // this cell is the tail slot being written
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/tqr_cell.sv
// ----------------------------------------------------------------------------
// tqr_cell: one storage slot of a queue
// Holds one key and payload. Compares its key against the search key, passes
// the running "already matched" flag and the matched entry down the row, and
// each cycle either holds, loads the tail entry or takes its right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module tqr_cell #(
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 7
) (
  input  wire                        clk_i,
  input  tqr_pkg::cell_ctrl_t        ctrl_i,
  input  wire                        occupied_i,
  input  wire  [KEY_BITS-1:0]        cmp_key_i,
  input  wire  [KEY_BITS-1:0]        tail_key_i,
  input  wire  [PAYLOAD_BITS-1:0]    tail_pay_i,
  input  wire  [KEY_BITS-1:0]        nbr_key_i,
  input  wire  [PAYLOAD_BITS-1:0]    nbr_pay_i,
  input  wire                        hit_i,
  input  wire  [KEY_BITS-1:0]        found_key_i,
  input  wire  [PAYLOAD_BITS-1:0]    found_pay_i,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [PAYLOAD_BITS-1:0]    pay_o,
  output logic                       hit_o,
  output logic [KEY_BITS-1:0]        found_key_o,
  output logic [PAYLOAD_BITS-1:0]    found_pay_o
);
  import tqr_pkg::*;

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    hit_here;
  logic                    first_hit;
  logic                    shift;

  // Match on an occupied slot; the first match in the row is the one taken
  assign hit_here  = occupied_i && (key_q == cmp_key_i);
  assign first_hit = hit_here && !hit_i;
  assign hit_o     = hit_i || hit_here;

  // Matched entry rides down the row as an OR chain
  assign found_key_o = found_key_i | (first_hit ? key_q : '0);
  assign found_pay_o = found_pay_i | (first_hit ? pay_q : '0);

  // Close the gap from the removed slot onwards
  assign shift = ctrl_i.shift_all || (ctrl_i.key_en && hit_o);

  // Next slot contents
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.load) begin
      key_d = tail_key_i;
      pay_d = tail_pay_i;
    end else if (shift) begin
      key_d = nbr_key_i;
      pay_d = nbr_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

### design/tqr_queue.sv
// ----------------------------------------------------------------------------
// tqr_queue: one ordered queue built as a row of cells
// Slot 0 is the head. A fill counter marks the occupied slots; push writes
// the slot at the fill count, pop and keyed delete shift the row left.
// ----------------------------------------------------------------------------
`default_nettype none

module tqr_queue #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 7,
  parameter int unsigned CW           = $clog2(DEPTH + 1)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  tqr_pkg::q_ctrl_t           op_i,
  input  wire  [KEY_BITS-1:0]        push_key_i,
  input  wire  [PAYLOAD_BITS-1:0]    push_pay_i,
  input  wire  [KEY_BITS-1:0]        cmp_key_i,
  output logic [CW-1:0]              fill_o,
  output logic [KEY_BITS-1:0]        head_key_o,
  output logic [PAYLOAD_BITS-1:0]    head_pay_o,
  output logic                       hit_o,
  output logic [KEY_BITS-1:0]        found_key_o,
  output logic [PAYLOAD_BITS-1:0]    found_pay_o
);
  import tqr_pkg::*;

  logic [CW-1:0] fill_q, fill_d;

  logic [KEY_BITS-1:0]     key_w   [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_w   [DEPTH];
  logic [KEY_BITS-1:0]     nkey_w  [DEPTH];
  logic [PAYLOAD_BITS-1:0] npay_w  [DEPTH];
  logic [DEPTH:0]          hit_w;
  logic [KEY_BITS-1:0]     fkey_w  [DEPTH+1];
  logic [PAYLOAD_BITS-1:0] fpay_w  [DEPTH+1];

  assign hit_w[0]  = 1'b0;
  assign fkey_w[0] = '0;
  assign fpay_w[0] = '0;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;

    if (i == DEPTH - 1) begin : g_last
      assign nkey_w[i] = '0;
      assign npay_w[i] = '0;
    end else begin : g_mid
      assign nkey_w[i] = key_w[i+1];
      assign npay_w[i] = pay_w[i+1];
    end

    assign ctrl.shift_all = op_i.pop_head;
    assign ctrl.key_en    = op_i.del_key;
    assign ctrl.load      = op_i.push && (fill_q == CW'(i));

    tqr_cell #(
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CW'(i) < fill_q),
      .cmp_key_i  (cmp_key_i),
      .tail_key_i (push_key_i),
      .tail_pay_i (push_pay_i),
      .nbr_key_i  (nkey_w[i]),
      .nbr_pay_i  (npay_w[i]),
      .hit_i      (hit_w[i]),
      .found_key_i(fkey_w[i]),
      .found_pay_i(fpay_w[i]),
      .key_o      (key_w[i]),
      .pay_o      (pay_w[i]),
      .hit_o      (hit_w[i+1]),
      .found_key_o(fkey_w[i+1]),
      .found_pay_o(fpay_w[i+1])
    );
  end

  // Fill count: the top level only issues legal operations
  always_comb begin
    fill_d = fill_q;
    if (op_i.push) begin
      fill_d = fill_q + CW'(1);
    end else if (op_i.pop_head || (op_i.del_key && hit_w[DEPTH])) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign fill_o      = fill_q;
  assign head_key_o  = key_w[0];
  assign head_pay_o  = pay_w[0];
  assign hit_o       = hit_w[DEPTH];
  assign found_key_o = fkey_w[DEPTH];
  assign found_pay_o = fpay_w[DEPTH];

endmodule

`default_nettype wire

### design/two_queue_rotation_with_keyed_removal_top.sv
// ----------------------------------------------------------------------------
// two_queue_rotation_with_keyed_removal_top: waiting and active queues
// Two ordered queues of keyed entries sharing one capacity, with arrive,
// enter, leave and remove-by-key requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request (mode, key, payload on req_i) is taken at a rising edge where
//   start_i is high and busy_o is low. busy_o stays low, so a request may be
//   issued on every cycle.
//   Each request gives exactly one result on res_o, shown for one cycle with
//   valid_o high, in the cycle after the request was taken.
//   Throughput is one request per cycle: each queue is a row of cells that
//   compare their keys in parallel and shift left together, with the
//   first-match flag rippling along the row.
//   The result is registered, so the next request is taken while the result
//   of the previous one is on the outputs. The receiver cannot stall; a
//   result not captured in its cycle is gone.
//   Status: done, source queue empty, key not found, or full and dropped.
//   Entry fields are zero unless the status is done.
//   Reset (rst_ni low, asynchronous) empties both queues and clears valid_o;
//   no clearing pass is needed, slot contents are ignored beyond the fills.
// ----------------------------------------------------------------------------
`default_nettype none

module two_queue_rotation_with_keyed_removal_top #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 7
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  output logic            busy_o,
  input  tqr_pkg::req_t   req_i,
  output logic            valid_o,
  output tqr_pkg::res_t   res_o
);
  import tqr_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                    accept;
  logic [KEY_BITS-1:0]     key_s;
  logic [PAYLOAD_BITS-1:0] pay_s;
  logic [CW:0]             total;

  q_ctrl_t                 w_op, a_op;
  logic [KEY_BITS-1:0]     w_push_key, a_push_key;
  logic [PAYLOAD_BITS-1:0] w_push_pay, a_push_pay;
  logic [CW-1:0]           w_fill, a_fill;
  logic [KEY_BITS-1:0]     w_head_key, a_head_key, w_found_key, a_found_key;
  logic [PAYLOAD_BITS-1:0] w_head_pay, a_head_pay, w_found_pay, a_found_pay;
  logic                    w_hit, a_hit;

  status_e                 status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_pay;
  logic [CW-1:0]           w_fill_nx, a_fill_nx;

  res_t res_q, res_d;
  logic valid_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Request fields at the stored widths
  assign key_s = KEY_BITS'(req_i.key);
  assign pay_s = PAYLOAD_BITS'(req_i.payload);
  assign total = {1'b0, w_fill} + {1'b0, a_fill};

  // Command decode into per-queue operations
  always_comb begin
    w_op       = '0;
    a_op       = '0;
    w_push_key = key_s;
    w_push_pay = pay_s;
    a_push_key = w_head_key;
    a_push_pay = w_head_pay;
    status     = ST_DONE;
    out_key    = '0;
    out_pay    = '0;
    w_fill_nx  = w_fill;
    a_fill_nx  = a_fill;
    case (req_i.mode)
      CMD_ARRIVE: begin
        if (total >= (CW+1)'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          w_op.push = accept;
          out_key   = key_s;
          out_pay   = pay_s;
          w_fill_nx = w_fill + CW'(1);
        end
      end
      CMD_ENTER: begin
        if (w_fill == '0) begin
          status = ST_EMPTY;
        end else begin
          w_op.pop_head = accept;
          a_op.push     = accept;
          out_key       = w_head_key;
          out_pay       = w_head_pay;
          w_fill_nx     = w_fill - CW'(1);
          a_fill_nx     = a_fill + CW'(1);
        end
      end
      CMD_LEAVE: begin
        w_push_key = a_head_key;
        w_push_pay = a_head_pay;
        if (a_fill == '0) begin
          status = ST_EMPTY;
        end else begin
          a_op.pop_head = accept;
          w_op.push     = accept;
          out_key       = a_head_key;
          out_pay       = a_head_pay;
          a_fill_nx     = a_fill - CW'(1);
          w_fill_nx     = w_fill + CW'(1);
        end
      end
      CMD_REMOVE: begin
        // Active queue is searched first
        a_op.del_key = accept;
        w_op.del_key = accept && !a_hit;
        if (a_hit) begin
          out_key   = a_found_key;
          out_pay   = a_found_pay;
          a_fill_nx = a_fill - CW'(1);
        end else if (w_hit) begin
          out_key   = w_found_key;
          out_pay   = w_found_pay;
          w_fill_nx = w_fill - CW'(1);
        end else begin
          status = ST_MISS;
        end
      end
      default: begin
        status = ST_MISS;
      end
    endcase
  end

  tqr_queue #(
    .DEPTH       (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .CW          (CW)
  ) u_waiting (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (w_op),
    .push_key_i (w_push_key),
    .push_pay_i (w_push_pay),
    .cmp_key_i  (key_s),
    .fill_o     (w_fill),
    .head_key_o (w_head_key),
    .head_pay_o (w_head_pay),
    .hit_o      (w_hit),
    .found_key_o(w_found_key),
    .found_pay_o(w_found_pay)
  );

  tqr_queue #(
    .DEPTH       (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .CW          (CW)
  ) u_active (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (a_op),
    .push_key_i (a_push_key),
    .push_pay_i (a_push_pay),
    .cmp_key_i  (key_s),
    .fill_o     (a_fill),
    .head_key_o (a_head_key),
    .head_pay_o (a_head_pay),
    .hit_o      (a_hit),
    .found_key_o(a_found_key),
    .found_pay_o(a_found_pay)
  );

  // Result assembly
  always_comb begin
    res_d               = '0;
    res_d.status        = status;
    res_d.entry_key     = KEY_W'(out_key);
    res_d.entry_payload = PAY_W'(out_pay);
    res_d.waiting_count = CNT_W'(w_fill_nx);
    res_d.active_count  = CNT_W'(a_fill_nx);
  end

  // Result register: payload without reset, strobe with reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  // Every taken request gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("request taken without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !valid_o)
    else $error("result without a request");

  // Shared capacity is never exceeded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CW+1)'(CAPACITY))
    else $error("queues exceed capacity");

  // A dropped arrival is only reported with both queues filling the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.status == ST_FULL) |->
      total == (CW+1)'(CAPACITY))
    else $error("full reported below capacity");

  // The fills reported match the counters after the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.waiting_count == CNT_W'(w_fill) &&
                 res_o.active_count == CNT_W'(a_fill)))
    else $error("reported counts disagree with queue fills");
`endif

endmodule

`default_nettype wire

### tb/tb_two_queue_rotation_with_keyed_removal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_queue_rotation_with_keyed_removal_top: request/result check
// Drives arrive, enter, leave and remove requests into the two-queue block.
// A scoreboard keeps its own waiting and active lines and predicts every
// result. A short directed run covers the empty, full, miss and duplicate-key
// cases. Random traffic follows in three phases of sender idling, with a full
// drain before every (N_RANDOM / 3)-th random request.
// ----------------------------------------------------------------------------

module tb_two_queue_rotation_with_keyed_removal_top;
  import tqr_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned N_RANDOM    = 650;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 4;

  // One stored entry, as the scoreboard keeps it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // One request waiting to be issued, with its issue policy
  typedef struct {
    req_t        req;
    bit          drain;     // hold off until every result is back
    int unsigned idle_pct;  // chance of an idle cycle before issue
  } pending_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic valid_o;
  res_t res_o;

  pending_t         pend_q[$];
  res_t             expect_q[$];
  slot_t            waiting_line[$];
  slot_t            active_line[$];
  logic [KEY_W-1:0] key_pool[6];
  int unsigned      taken_cnt = 0;
  int unsigned      done_cnt  = 0;
  int unsigned      errors    = 0;
  int unsigned      peak_fill = 0;
  int unsigned      stall_cycles = 0;
  int unsigned      status_seen[4] = '{default: 0};

  two_queue_rotation_with_keyed_removal_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // Apply one request to the scoreboard queues and return the expected result
  function automatic res_t apply_cmd(req_t rq);
    res_t  r;
    slot_t s;
    bit    hit;
    r   = '0;
    s   = '0;
    hit = 1'b0;
    r.status = ST_DONE;
    case (rq.mode)
      CMD_ARRIVE: begin
        if (waiting_line.size() + active_line.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          s = '{rq.key, rq.payload};
          waiting_line = {waiting_line, s};
        end
      end
      CMD_ENTER: begin
        if (waiting_line.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = waiting_line[0];
          waiting_line.delete(0);
          active_line = {active_line, s};
        end
      end
      CMD_LEAVE: begin
        if (active_line.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = active_line[0];
          active_line.delete(0);
          waiting_line = {waiting_line, s};
        end
      end
      default: begin
        // first match wins, active line searched before waiting line
        for (int i = 0; i < active_line.size() && !hit; i++) begin
          if (active_line[i].key == rq.key) begin
            s = active_line[i];
            active_line.delete(i);
            hit = 1'b1;
          end
        end
        for (int i = 0; i < waiting_line.size() && !hit; i++) begin
          if (waiting_line[i].key == rq.key) begin
            s = waiting_line[i];
            waiting_line.delete(i);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_MISS;
      end
    endcase
    r.entry_key     = s.key;
    r.entry_payload = s.payload;
    r.waiting_count = CNT_W'(waiting_line.size());
    r.active_count  = CNT_W'(active_line.size());
    if (waiting_line.size() + active_line.size() > peak_fill)
      peak_fill = waiting_line.size() + active_line.size();
    status_seen[r.status]++;
    return r;
  endfunction

  function automatic void add_cmd(cmd_e m, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                  bit drain, int unsigned idle);
    pending_t item;
    item.req      = '{m, k, p};
    item.drain    = drain;
    item.idle_pct = idle;
    pend_q = {pend_q, item};
  endfunction

  // Mostly keys from a small pool, so that removals hit and duplicates occur
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, 5)];
    return KEY_W'($urandom());
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: presents the head of the pending queue
  always @(posedge clk_i) begin : drv
    bit go;
    if (rst_ni && !(start_i && busy_o)) begin
      if (start_i) pend_q.delete(0);
      go = pend_q.size() != 0 && $urandom_range(0, 99) >= pend_q[0].idle_pct;
      // a drain point waits for the last outstanding result
      if (go && pend_q[0].drain && (start_i || taken_cnt != done_cnt)) go = 1'b0;
      start_i <= go;
      if (go) req_i <= pend_q[0].req;
    end
  end

  // Monitor: checks each result, then predicts the request taken at this edge
  always @(posedge clk_i) begin : mon
    res_t want;
    res_t pred;
    if (rst_ni) begin
      if (valid_o) begin
        done_cnt <= done_cnt + 1;
        if (expect_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expect_q[0];
          expect_q.delete(0);
          check_field("status", want.status, res_o.status);
          check_field("entry_key", want.entry_key, res_o.entry_key);
          check_field("entry_payload", want.entry_payload, res_o.entry_payload);
          check_field("waiting_count", want.waiting_count, res_o.waiting_count);
          check_field("active_count", want.active_count, res_o.active_count);
        end
      end
      if (start_i && !busy_o) begin
        pred = apply_cmd(req_i);
        expect_q = {expect_q, pred};
        taken_cnt <= taken_cnt + 1;
      end
      // watchdog on cycles with no request and no result
      if (valid_o || (start_i && !busy_o)) begin
        stall_cycles = 0;
      end else if (++stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request or result for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : main
    int unsigned r;
    int unsigned idle;
    cmd_e        m;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom());

    // empty block: nothing to move or remove
    add_cmd(CMD_REMOVE, 16'hBEEF, 7'd0, 1'b0, 0);
    add_cmd(CMD_ENTER, 16'h0000, 7'd0, 1'b0, 0);
    add_cmd(CMD_LEAVE, 16'hFFFF, 7'h7F, 1'b0, 0);
    // fill to capacity, with extreme and duplicate keys
    add_cmd(CMD_ARRIVE, 16'h1234, 7'd1, 1'b0, 0);
    add_cmd(CMD_ARRIVE, 16'h0000, 7'd0, 1'b0, 0);
    add_cmd(CMD_ARRIVE, 16'hFFFF, 7'h7F, 1'b0, 0);
    add_cmd(CMD_ARRIVE, 16'h1234, 7'd2, 1'b0, 0);
    for (int i = 0; i < 12; i++) begin
      add_cmd(CMD_ARRIVE, 16'hA500 + KEY_W'(i * 37), PAY_W'(i * 11), 1'b0, 0);
    end
    // one too many is dropped
    add_cmd(CMD_ARRIVE, 16'h5555, 7'h2A, 1'b0, 0);
    add_cmd(CMD_ENTER, 16'h0000, 7'd0, 1'b0, 0);
    add_cmd(CMD_ENTER, 16'h0000, 7'd0, 1'b0, 0);
    add_cmd(CMD_LEAVE, 16'h0000, 7'd0, 1'b0, 0);
    // duplicate key, active line hit, then a miss
    add_cmd(CMD_REMOVE, 16'h1234, 7'h7F, 1'b0, 0);
    add_cmd(CMD_REMOVE, 16'h0000, 7'd0, 1'b0, 0);
    add_cmd(CMD_REMOVE, 16'hBEEF, 7'd0, 1'b0, 0);

    // random traffic: light sender idling, then heavy, then none
    for (int i = 0; i < N_RANDOM; i++) begin
      idle = (i < N_RANDOM / 3) ? 9 : (i < 2 * N_RANDOM / 3) ? 51 : 0;
      r = $urandom_range(0, 99);
      if (r < 35) m = CMD_ARRIVE;
      else if (r < 55) m = CMD_ENTER;
      else if (r < 70) m = CMD_LEAVE;
      else m = CMD_REMOVE;
      add_cmd(m, pick_key(), PAY_W'($urandom()), (i % (N_RANDOM / 3)) == 0, idle);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pend_q.size() != 0 || start_i || taken_cnt != done_cnt);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expect_q.size() != 0) begin
      $error("%0d results never arrived", expect_q.size());
      errors++;
    end
    $display("Ran %0d requests: %0d done, %0d source empty, %0d key miss, %0d dropped full",
             taken_cnt, status_seen[ST_DONE], status_seen[ST_EMPTY],
             status_seen[ST_MISS], status_seen[ST_FULL]);
    $display("Peak occupancy %0d of %0d entries", peak_fill, QUEUE_DEPTH);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
